/* sv/tfsac_pkg.sv */
// Shared types and constants for the telemetry frame builder.
package tfsac_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] DEST_RESET = 8'hFF;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] func_code;
        logic [7:0] frame_len;
        logic       has_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       count_error;
    } out_item_t;

    typedef enum logic [2:0] {
        STEP_HDR  = 3'd0,
        STEP_DEST = 3'd1,
        STEP_FUNC = 3'd2,
        STEP_LEN  = 3'd3,
        STEP_DATA = 3'd4,
        STEP_SUM  = 3'd5,
        STEP_ADD  = 3'd6
    } step_t;

    localparam int NUM_STEPS = 7;

endpackage

/* sv/tfsac_frame_seq.sv */
// Item register, byte sequencer and check accumulators.
module tfsac_frame_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          dest_addr,
    input  logic                item_valid,
    output logic                item_ready,
    input  tfsac_pkg::in_item_t item,
    output logic                emit_valid,
    input  logic                emit_ready,
    output tfsac_pkg::out_item_t emit
);
    import tfsac_pkg::*;

    in_item_t          item_reg;
    logic              item_valid_reg;
    logic [2:0]        step_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        add_reg;
    logic [7:0]        count_reg;
    logic [7:0]        expected_reg;
    logic              in_frame_reg;
    logic              over_reg;

    logic [NUM_STEPS-1:0] en;
    logic [NUM_STEPS-1:0] rem;
    logic              open_frame;
    logic [2:0]        cur;
    logic              more;
    logic              fire;
    logic              done;
    logic              accept;
    logic [7:0]        byte_sel;
    logic [7:0]        sum_base;
    logic [7:0]        add_base;
    logic [7:0]        sum_next;
    logic [7:0]        add_next;
    logic              count_err;

    always_comb
    begin
        open_frame = item_reg.first || in_frame_reg;
        en[STEP_HDR]  = item_reg.first;
        en[STEP_DEST] = item_reg.first;
        en[STEP_FUNC] = item_reg.first;
        en[STEP_LEN]  = item_reg.first;
        en[STEP_DATA] = item_reg.has_byte && open_frame;
        en[STEP_SUM]  = item_reg.last && open_frame;
        en[STEP_ADD]  = item_reg.last && open_frame;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            rem[i] = en[i] && (3'(i) >= step_reg);
        end
        // lowest pending step
        cur = 3'd0;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
        begin
            if (rem[i])
            begin
                cur = 3'(i);
            end
        end
        more = 1'b0;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if (rem[i] && (3'(i) > cur))
            begin
                more = 1'b1;
            end
        end
    end

    assign count_err = over_reg || (count_reg != expected_reg);

    always_comb
    begin
        unique case (cur)
            STEP_HDR:  byte_sel = HDR_BYTE;
            STEP_DEST: byte_sel = dest_addr;
            STEP_FUNC: byte_sel = item_reg.func_code;
            STEP_LEN:  byte_sel = item_reg.frame_len;
            STEP_DATA: byte_sel = item_reg.data_byte;
            STEP_SUM:  byte_sel = sum_reg;
            STEP_ADD:  byte_sel = add_reg;
            default:   byte_sel = 8'h00;
        endcase
        // the header byte opens fresh accumulators
        sum_base = (cur == STEP_HDR) ? 8'h00 : sum_reg;
        add_base = (cur == STEP_HDR) ? 8'h00 : add_reg;
        sum_next = sum_base + byte_sel;
        add_next = add_base + sum_next;
    end

    assign emit_valid = item_valid_reg && (|rem);
    assign fire       = emit_valid && emit_ready;
    assign done       = item_valid_reg && (!(|rem) || (fire && !more));
    assign item_ready = !item_valid_reg || done;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        emit.out_byte    = byte_sel;
        emit.run_last    = !more;
        emit.frame_end   = (cur == STEP_ADD);
        emit.count_error = (cur == STEP_ADD) && count_err;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                step_reg       <= 3'd0;
            end
            else if (done)
            begin
                item_valid_reg <= 1'b0;
                step_reg       <= 3'd0;
            end
            else if (fire)
            begin
                step_reg <= cur + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= 8'h00;
            add_reg      <= 8'h00;
            count_reg    <= 8'h00;
            expected_reg <= 8'h00;
            in_frame_reg <= 1'b0;
            over_reg     <= 1'b0;
        end
        else if (fire)
        begin
            if (cur <= STEP_DATA)
            begin
                sum_reg <= sum_next;
                add_reg <= add_next;
            end
            if (cur == STEP_HDR)
            begin
                count_reg    <= 8'h00;
                over_reg     <= 1'b0;
                expected_reg <= item_reg.frame_len;
                in_frame_reg <= 1'b1;
            end
            if (cur == STEP_DATA)
            begin
                // saturate the count, remember the overflow
                if (count_reg == COUNT_MAX)
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 8'd1;
                end
            end
            if (cur == STEP_ADD)
            begin
                in_frame_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/tfsac_out_skid.sv */
// Output register with a skid stage for the result channel.
module tfsac_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  tfsac_pkg::out_item_t up_data,
    output logic                 down_valid,
    input  logic                 down_ready,
    output tfsac_pkg::out_item_t down_data
);
    import tfsac_pkg::*;

    out_item_t out_reg;
    out_item_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      up_fire;
    logic      load_out;
    logic      load_skid;
    logic      pop_skid;

    assign up_ready   = !skid_valid_reg;
    assign up_fire    = up_valid && up_ready;
    assign pop_skid   = skid_valid_reg && down_ready;
    assign load_out   = up_fire && (!out_valid_reg || down_ready);
    assign load_skid  = up_fire && out_valid_reg && !down_ready;
    assign down_valid = out_valid_reg;
    assign down_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (pop_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (load_out)
        begin
            out_reg <= up_data;
        end
        if (load_skid)
        begin
            skid_reg <= up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_skid)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (load_skid)
            begin
                skid_valid_reg <= 1'b1;
            end
            if (pop_skid || load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (down_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/telemetry_frame_sum_add_check.sv */
// Top level of the telemetry frame builder with sum and add checks.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------
//  item     | item_valid / item_ready    | item   (in_item_t)
//  result   | result_valid / result_ready| result (out_item_t)
//  cfg      | cfg_valid / cfg_ready      | cfg_data (dest_addr)
//
// Each item emits its 0 to 7 bytes at one byte per cycle from the item
// register while the skid stage accepts them; payload-only items likewise
// pass at one per cycle. The output register plus skid stage keeps the
// result side registered. Reset clears the accumulators, closes any frame
// and sets dest_addr to 0xFF. cfg_ready is always high.
module telemetry_frame_sum_add_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tfsac_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tfsac_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);
    import tfsac_pkg::*;

    logic [7:0] dest_reg;
    logic       emit_valid;
    logic       emit_ready;
    out_item_t  emit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= DEST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dest_reg <= cfg_data;
        end
    end

    tfsac_frame_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .dest_addr  (dest_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    tfsac_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (emit_valid),
        .up_ready   (emit_ready),
        .up_data    (emit),
        .down_valid (result_valid),
        .down_ready (result_ready),
        .down_data  (result)
    );

endmodule
